// ===== hw/rtl/region_slot_table_core_macros.svh =====
// assertion helpers for the region slot table core
`ifndef REGION_SLOT_TABLE_CORE_MACROS_SVH
`define REGION_SLOT_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSLOT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RSLOT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rslot_pkg.sv =====
package rslot_pkg;

  localparam int POS_W    = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int OCC_W    = 7;
  localparam int RADIUS_W = 7;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 7'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_UNLOAD = 2'd2,
    CMD_EVICT  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EVICTED = 3'd4,
    ST_NONE    = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic sweep_rd;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_end;
  } dp_stat_t;

endpackage

// ===== hw/rtl/region_slot_table_core.sv =====
// region slot table: SLOTS slots, each holding a signed x/y region coordinate
// input channel: a command word (lookup, load, unload, evict far slots) with
//   pos and center ports is taken at a clock edge where start is high and
//   busy is low
// output channel: each result word is flagged by valid_o for exactly one
//   cycle; last_o marks the final word of a command
// lookup, load and unload: match over all slot cells in the accept cycle,
//   decision and table update in the next; the result word is registered as
//   the execute state ends and busy drops with it, so words do not overlap
// evict: a read pointer walks the slot memory one slot per cycle with the
//   distance compare one stage behind, and busy stays high through the walk
//   and the drain and finish states; one result word per freed slot comes out,
//   the last one at the walk's end, or a single "nothing evicted" word there
// radius: cfg_we_i / cfg_wdata_i, write only while idle (the block does not enforce it), no read-back
// reset: every slot free, count zero, radius 8; no clearing pass is needed
// the receiver cannot stall, so result words are never held back
`include "region_slot_table_core_macros.svh"

module region_slot_table_core #(
  parameter int SLOTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rslot_pkg::CMD_W-1:0]          command_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   center_x_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   center_y_i,
  // radius register
  input  logic                                 cfg_we_i,
  input  logic [rslot_pkg::RADIUS_W-1:0]       cfg_wdata_i,
  // result channel
  output logic                                 valid_o,
  output logic [rslot_pkg::STATUS_W-1:0]       status_o,
  output logic [rslot_pkg::SLOT_W-1:0]         slot_o,
  output logic signed [rslot_pkg::POS_W-1:0]   out_x_o,
  output logic signed [rslot_pkg::POS_W-1:0]   out_y_o,
  output logic [rslot_pkg::OCC_W-1:0]          occupied_count_o,
  output logic                                 last_o
);
  import rslot_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t dp_stat;

  // sequencing: idle, single-word execute, evict walk and its wind-down
  rslot_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .ctrl_o    (ctrl),
    .busy      (busy)
  );

  // slot cells, slot memory, count, radius and the result register
  rslot_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (dp_stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .occupied_count_o (occupied_count_o),
    .last_o           (last_o)
  );

  // an accepted word always keeps the block busy for the next cycle
  `RSLOT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  // a word that is not the last one can only come out of an evict walk still in progress
  `RSLOT_ASSERT_IMP(a_mid_word_busy, valid_o && !last_o, busy, "non-final word while idle")
  // only evicted words come in runs
  `RSLOT_ASSERT_IMP(a_single_last, valid_o && (status_o != ST_EVICTED), last_o, "single word without last")
  // occupancy never exceeds the table size
  `RSLOT_ASSERT_IMP(a_count_range, valid_o, occupied_count_o <= SLOTS, "occupied count out of range")

endmodule

// ===== hw/rtl/rslot_ctrl.sv =====
module rslot_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [rslot_pkg::CMD_W-1:0]   command_i,
  input  rslot_pkg::dp_stat_t           stat_i,
  output rslot_pkg::ctrl_t              ctrl_o,
  output logic                          busy
);
  import rslot_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.capture = 1'b1;
          state_d = (cmd_e'(command_i) == CMD_EVICT) ? S_SWEEP : S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      S_SWEEP: begin
        ctrl_o.sweep_rd = 1'b1;
        if (stat_i.sweep_end) begin
          state_d = S_DRAIN;
        end
      end
      // last slot read is compared here
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        ctrl_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/rslot_dp.sv =====
module rslot_dp #(
  parameter int SLOTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rslot_pkg::ctrl_t                     ctrl_i,
  output rslot_pkg::dp_stat_t                  stat_o,
  input  logic                                 cfg_we_i,
  input  logic [rslot_pkg::RADIUS_W-1:0]       cfg_wdata_i,
  input  logic [rslot_pkg::CMD_W-1:0]          command_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   center_x_i,
  input  logic signed [rslot_pkg::POS_W-1:0]   center_y_i,
  output logic                                 valid_o,
  output logic [rslot_pkg::STATUS_W-1:0]       status_o,
  output logic [rslot_pkg::SLOT_W-1:0]         slot_o,
  output logic signed [rslot_pkg::POS_W-1:0]   out_x_o,
  output logic signed [rslot_pkg::POS_W-1:0]   out_y_o,
  output logic [rslot_pkg::OCC_W-1:0]          occupied_count_o,
  output logic                                 last_o
);
  import rslot_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int DW = POS_W + 2;

  function automatic logic [IW-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  // configuration
  logic [RADIUS_W-1:0] radius_q;

  // slot state
  logic [SLOTS-1:0]         used_q, used_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic signed [POS_W-1:0]  cam_x_q [SLOTS];
  logic signed [POS_W-1:0]  cam_y_q [SLOTS];
  logic signed [POS_W-1:0]  mem_x [SLOTS];
  logic signed [POS_W-1:0]  mem_y [SLOTS];

  // captured word
  cmd_e                     cmd_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q, cx_q, cy_q;
  logic [SLOTS-1:0]         match_q, match_d;

  // sweep pipeline
  logic [IW-1:0]            addr_q;
  logic                     rd_vld_q;
  logic [IW-1:0]            rd_idx_q;
  logic signed [POS_W-1:0]  rd_x_q, rd_y_q;
  logic                     pend_vld_q;
  logic [IW-1:0]            pend_idx_q;
  logic signed [POS_W-1:0]  pend_x_q, pend_y_q;
  logic [CW-1:0]            pend_cnt_q;

  // result register
  logic                     valid_q, valid_d;
  status_e                  status_q, status_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic signed [POS_W-1:0]  out_x_q, out_x_d, out_y_q, out_y_d;
  logic [OCC_W-1:0]         occ_q, occ_d;
  logic                     last_q, last_d;

  // single-word decision
  logic                     hit_any, free_any;
  logic [IW-1:0]            hit_idx, free_idx, res_idx;
  logic                     wr_slot, clr_slot, res_hit;
  status_e                  res_st;

  // distance check
  logic signed [DW-1:0]     dx, dy, r_s;
  logic                     far, evict_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // parallel match of every occupied cell against the incoming position
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_d[i] = used_q[i] && (cam_x_q[i] == pos_x_i) && (cam_y_q[i] == pos_y_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_e'(command_i);
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      match_q <= match_d;
    end
  end

  assign hit_any  = |match_q;
  assign free_any = ~&used_q;
  assign hit_idx  = first_set(match_q);
  assign free_idx = first_set(~used_q);

  always_comb begin
    wr_slot  = 1'b0;
    clr_slot = 1'b0;
    res_hit  = 1'b1;
    res_idx  = hit_idx;
    res_st   = ST_OK;
    case (cmd_q)
      CMD_LOOKUP: begin
        if (!hit_any) begin
          res_st  = ST_ABSENT;
          res_hit = 1'b0;
        end
      end
      CMD_LOAD: begin
        if (hit_any) begin
          res_st = ST_PRESENT;
        end else if (free_any) begin
          wr_slot = ctrl_i.commit;
          res_idx = free_idx;
        end else begin
          res_st  = ST_FULL;
          res_hit = 1'b0;
        end
      end
      CMD_UNLOAD: begin
        if (hit_any) begin
          clr_slot = ctrl_i.commit;
        end else begin
          res_st  = ST_ABSENT;
          res_hit = 1'b0;
        end
      end
      default: begin
        res_st  = ST_NONE;
        res_hit = 1'b0;
      end
    endcase
  end

  // cells for matching, memory copy for the evict sweep
  always_ff @(posedge clk_i) begin
    if (wr_slot) begin
      cam_x_q[free_idx] <= pos_x_q;
      cam_y_q[free_idx] <= pos_y_q;
      mem_x[free_idx]   <= pos_x_q;
      mem_y[free_idx]   <= pos_y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sweep_rd) begin
      rd_x_q <= mem_x[addr_q];
      rd_y_q <= mem_y[addr_q];
    end
    rd_idx_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.sweep_rd;
      if (ctrl_i.capture) begin
        addr_q <= '0;
      end else if (ctrl_i.sweep_rd) begin
        addr_q <= addr_q + IW'(1);
      end
    end
  end

  assign stat_o.sweep_end = (addr_q == IW'(SLOTS - 1));

  // per-axis distance, exact on the widened range
  assign dx  = DW'(rd_x_q) - DW'(cx_q);
  assign dy  = DW'(rd_y_q) - DW'(cy_q);
  assign r_s = {{(DW - RADIUS_W){1'b0}}, radius_q};
  assign far = (dx > r_s) || (dx < -r_s) || (dy > r_s) || (dy < -r_s);
  assign evict_hit = rd_vld_q && used_q[rd_idx_q] && far;

  always_comb begin
    used_d = used_q;
    cnt_d  = cnt_q;
    if (wr_slot) begin
      used_d[free_idx] = 1'b1;
      cnt_d = cnt_q + CW'(1);
    end
    if (clr_slot) begin
      used_d[hit_idx] = 1'b0;
      cnt_d = cnt_q - CW'(1);
    end
    if (evict_hit) begin
      used_d[rd_idx_q] = 1'b0;
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      used_q  <= used_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      if (ctrl_i.capture) begin
        pend_vld_q <= 1'b0;
      end else if (evict_hit) begin
        pend_vld_q <= 1'b1;
      end
    end
  end

  // one freed slot is held back until the next one shows whether it is the last
  always_ff @(posedge clk_i) begin
    if (evict_hit) begin
      pend_idx_q <= rd_idx_q;
      pend_x_q   <= rd_x_q;
      pend_y_q   <= rd_y_q;
      pend_cnt_q <= cnt_d;
    end
  end

  always_comb begin
    valid_d  = ctrl_i.commit || (evict_hit && pend_vld_q) || ctrl_i.finish;
    status_d = ST_EVICTED;
    slot_d   = SLOT_W'(pend_idx_q);
    out_x_d  = pend_x_q;
    out_y_d  = pend_y_q;
    occ_d    = OCC_W'(pend_cnt_q);
    last_d   = 1'b1;
    if (ctrl_i.commit) begin
      status_d = res_st;
      slot_d   = res_hit ? SLOT_W'(res_idx) : '0;
      out_x_d  = res_hit ? pos_x_q : '0;
      out_y_d  = res_hit ? pos_y_q : '0;
      occ_d    = OCC_W'(cnt_d);
    end else if (evict_hit) begin
      last_d = 1'b0;
    end else if (!pend_vld_q) begin
      status_d = ST_NONE;
      slot_d   = '0;
      out_x_d  = '0;
      out_y_d  = '0;
      occ_d    = OCC_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      out_x_q  <= out_x_d;
      out_y_q  <= out_y_d;
      occ_q    <= occ_d;
      last_q   <= last_d;
    end
  end

  assign valid_o          = valid_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign occupied_count_o = occ_q;
  assign last_o           = last_q;

endmodule

// ===== verif/region_slot_table_core_tb.sv =====
module region_slot_table_core_tb;
  import rslot_pkg::*;

  localparam int SLOTS          = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  // one command word as handed to the block
  typedef struct {
    cmd_e                    cmd;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
  } cmd_word_t;

  // one result word as the block should report it
  typedef struct {
    status_e                 status;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [OCC_W-1:0]        occ;
    logic                    fin;
  } result_word_t;

  // dut inputs start at known values
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic [CMD_W-1:0]        command_i   = '0;
  logic signed [POS_W-1:0] pos_x_i     = '0;
  logic signed [POS_W-1:0] pos_y_i     = '0;
  logic signed [POS_W-1:0] center_x_i  = '0;
  logic signed [POS_W-1:0] center_y_i  = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [RADIUS_W-1:0]     cfg_wdata_i = '0;

  logic                    busy;
  logic                    valid_o;
  logic [STATUS_W-1:0]     status_o;
  logic [SLOT_W-1:0]       slot_o;
  logic signed [POS_W-1:0] out_x_o;
  logic signed [POS_W-1:0] out_y_o;
  logic [OCC_W-1:0]        occupied_count_o;
  logic                    last_o;

  region_slot_table_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .occupied_count_o(occupied_count_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // table shadow: occupied marks, coordinates, count and the radius register
  // ---------------------------------------------------------------------------
  logic                    held   [SLOTS];
  logic signed [POS_W-1:0] held_x [SLOTS];
  logic signed [POS_W-1:0] held_y [SLOTS];
  logic [OCC_W-1:0]        occ_total = '0;
  logic [RADIUS_W-1:0]     radius_q  = RADIUS_RST;

  cmd_word_t    cmd_backlog[$];      // words not yet handed to the block
  result_word_t pending_results[$];  // words the block still owes us
  cmd_word_t    cur_word;
  int           hold_cnt    = 0;
  int           idle_pct    = 0;
  int           fail_cnt    = 0;
  int           stall_cycles = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      held[i]   = 1'b0;
      held_x[i] = '0;
      held_y[i] = '0;
    end
  end

  // lowest occupied slot holding the position, -1 on a miss
  function automatic int find_held(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
    for (int i = 0; i < SLOTS; i++)
      if (held[i] && held_x[i] == x && held_y[i] == y) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < SLOTS; i++)
      if (!held[i]) return i;
    return -1;
  endfunction

  function automatic void owe_result(status_e st, int slot, logic signed [POS_W-1:0] x,
                                     logic signed [POS_W-1:0] y, logic fin);
    result_word_t r;
    r.status = st;
    r.slot   = SLOT_W'(slot);
    r.x      = x;
    r.y      = y;
    r.occ    = occ_total;
    r.fin    = fin;
    pending_results.push_back(r);
  endfunction

  // apply one accepted command to the shadow table and queue what it reports
  function automatic void apply_table_cmd(cmd_word_t w);
    int hit;
    int freed;
    int dx;
    int dy;
    hit   = -1;
    freed = 0;
    case (w.cmd)
      CMD_LOOKUP: begin
        hit = find_held(w.px, w.py);
        if (hit < 0) owe_result(ST_ABSENT, 0, '0, '0, 1'b1);
        else owe_result(ST_OK, hit, held_x[hit], held_y[hit], 1'b1);
      end
      CMD_LOAD: begin
        hit = find_held(w.px, w.py);
        if (hit >= 0) begin
          owe_result(ST_PRESENT, hit, held_x[hit], held_y[hit], 1'b1);
        end else begin
          hit = find_free();
          if (hit < 0) begin
            owe_result(ST_FULL, 0, '0, '0, 1'b1);
          end else begin
            held[hit]   = 1'b1;
            held_x[hit] = w.px;
            held_y[hit] = w.py;
            occ_total   = occ_total + 1'b1;
            owe_result(ST_OK, hit, w.px, w.py, 1'b1);
          end
        end
      end
      CMD_UNLOAD: begin
        hit = find_held(w.px, w.py);
        if (hit < 0) begin
          owe_result(ST_ABSENT, 0, '0, '0, 1'b1);
        end else begin
          held[hit] = 1'b0;
          if (occ_total != 0) occ_total = occ_total - 1'b1;
          owe_result(ST_OK, hit, held_x[hit], held_y[hit], 1'b1);
        end
      end
      default: begin
        // sweep in slot order, exact distances in 32-bit int
        for (int i = 0; i < SLOTS; i++) begin
          if (held[i]) begin
            dx = int'(held_x[i]) - int'(w.cx);
            dy = int'(held_y[i]) - int'(w.cy);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > int'(radius_q) || dy > int'(radius_q)) begin
              held[i] = 1'b0;
              if (occ_total != 0) occ_total = occ_total - 1'b1;
              owe_result(ST_EVICTED, i, held_x[i], held_y[i], 1'b0);
              freed++;
            end
          end
        end
        if (freed == 0) owe_result(ST_NONE, 0, '0, '0, 1'b1);
        else pending_results[pending_results.size()-1].fin = 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: a word is taken at an edge with start high and busy low; idle
  // bursts, timed by hold_cnt, are dropped in between at the phase's rate
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (start && !busy) apply_table_cmd(cur_word);
      if (!start || !busy) begin
        if (hold_cnt > 1) begin
          hold_cnt <= hold_cnt - 1;
          start    <= 1'b0;
        end else if (cmd_backlog.size() > 0 && hold_cnt == 0 &&
                     $urandom_range(99) < idle_pct) begin
          // start an idle burst, this cycle is its first
          hold_cnt <= $urandom_range(19, 1);
          start    <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cur_word = cmd_backlog.pop_front();
          hold_cnt   <= 0;
          start      <= 1'b1;
          command_i  <= cur_word.cmd;
          pos_x_i    <= cur_word.px;
          pos_y_i    <= cur_word.py;
          center_x_i <= cur_word.cx;
          center_y_i <= cur_word.cy;
        end else begin
          hold_cnt <= 0;
          start    <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed result word is matched against the oldest one owed
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_mon
    result_word_t w;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with none owed: status %0d slot %0d", status_o, slot_o);
        fail_cnt++;
      end else begin
        w = pending_results.pop_front();
        check_field("status", w.status, status_o);
        check_field("slot", w.slot, slot_o);
        check_field("out_x", w.x, out_x_o);
        check_field("out_y", w.y, out_y_o);
        check_field("occupied_count", w.occ, occupied_count_o);
        check_field("last", w.fin, last_o);
      end
    end
  end

  // watchdog: cycles with work outstanding but no word moving either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        stall_cycles <= 0;
      end else if (cmd_backlog.size() > 0 || pending_results.size() > 0 || start || busy) begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("region_slot_table_core_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_cmd(cmd_e c, int px, int py, int cx = 0, int cy = 0);
    cmd_word_t w;
    w.cmd = c;
    w.px  = POS_W'(px);
    w.py  = POS_W'(py);
    w.cx  = POS_W'(cx);
    w.cy  = POS_W'(cy);
    cmd_backlog.push_back(w);
  endtask

  // block idle: backlog handed over, every result in, and the evict walk
  // allowed to run out past its last freed slot
  task automatic wait_idle();
    while (cmd_backlog.size() > 0 || start) @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_q = r;
  endtask

  // clustered traffic: positions near a moving base so loads collide,
  // lookups and unloads hit, and evicts split the table; some full-range noise
  task automatic push_random(int n, int load_pct, int evict_pct);
    cmd_word_t               w;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    int                      spread;
    int                      r;
    bx     = '0;
    by     = '0;
    spread = 15;
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        bx = POS_W'($urandom);
        by = POS_W'($urandom);
        if ($urandom_range(3) == 0) bx = $urandom_range(1) ? 16'sh7ff0 : 16'sh8000;
        if ($urandom_range(3) == 0) by = $urandom_range(1) ? 16'sh7ff0 : 16'sh8000;
        case ($urandom_range(2))
          0:       spread = 3;
          1:       spread = 15;
          default: spread = 255;
        endcase
      end
      r = $urandom_range(99);
      if (r < load_pct) w.cmd = CMD_LOAD;
      else if (r < load_pct + evict_pct) w.cmd = CMD_EVICT;
      else if (r[0]) w.cmd = CMD_LOOKUP;
      else w.cmd = CMD_UNLOAD;
      w.px = bx + POS_W'($urandom_range(spread));
      w.py = by + POS_W'($urandom_range(spread));
      if ($urandom_range(15) == 0) w.px = POS_W'($urandom);
      if ($urandom_range(15) == 0) w.py = POS_W'($urandom);
      w.cx = bx + POS_W'($urandom_range(spread));
      w.cy = by + POS_W'($urandom_range(spread));
      if ($urandom_range(7) == 0) w.cx = POS_W'($urandom);
      if ($urandom_range(7) == 0) w.cy = POS_W'($urandom);
      cmd_backlog.push_back(w);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, on the reset radius of 8
    idle_pct = 30;
    push_cmd(CMD_LOOKUP, 0, 0);                       // empty table misses
    push_cmd(CMD_UNLOAD, 0, 0);
    push_cmd(CMD_EVICT, 0, 0, 0, 0);                  // nothing to evict
    push_cmd(CMD_LOAD, -32768, -32768);
    push_cmd(CMD_LOAD, 32767, 32767);
    push_cmd(CMD_LOAD, -32768, 32767);
    push_cmd(CMD_LOAD, 0, 0);
    push_cmd(CMD_LOAD, 32767, -32768);
    push_cmd(CMD_LOAD, 0, 0);                         // already present
    push_cmd(CMD_LOOKUP, 32767, 32767);
    push_cmd(CMD_LOOKUP, 1, 0);
    push_cmd(CMD_UNLOAD, 0, 0);
    push_cmd(CMD_LOAD, 8, -8);                        // reuses the freed slot
    push_cmd(CMD_LOOKUP, 0, 0);                       // freed slot must not match
    push_cmd(CMD_LOAD, -8, 8);
    push_cmd(CMD_LOAD, 9, 0);
    push_cmd(CMD_EVICT, 0, 0, 0, 0);                  // distance 8 stays, 9 goes
    push_cmd(CMD_EVICT, 0, 0, 0, 0);
    push_cmd(CMD_LOAD, 32767, 32767);
    push_cmd(CMD_EVICT, 0, 0, -32768, -32768);        // widest distance, no wrap
    push_cmd(CMD_LOAD, -1, -1);
    push_cmd(CMD_LOOKUP, -1, -1);
    wait_idle();

    // radius zero: everything off the centre goes
    write_radius(0);
    push_cmd(CMD_LOAD, 100, 100);
    push_cmd(CMD_LOAD, 100, 101);
    push_cmd(CMD_EVICT, 0, 0, 100, 100);
    wait_idle();

    write_radius(127);
    idle_pct = 20;
    push_random(80, 50, 10);
    wait_idle();

    // load-heavy run with no evicts so the table fills up
    write_radius(1);
    idle_pct = 10;
    push_random(100, 90, 0);
    wait_idle();

    write_radius(0);
    idle_pct = 40;
    push_random(60, 40, 20);
    wait_idle();

    write_radius(RADIUS_W'($urandom_range(126, 2)));
    idle_pct = 25;
    push_random(80, 50, 15);
    wait_idle();

    // closing stretch at full rate, no idling
    write_radius(RADIUS_RST);
    idle_pct = 0;
    push_random(80, 50, 15);
    wait_idle();

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("region_slot_table_core_tb: PASS");
    end else begin
      $display("region_slot_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule
